// File: design/lprpe_pkg.sv
// Shared types and constants of the palette and run-length pixel encoder.
`default_nettype none

package lprpe_pkg;

  // Palette geometry: entries are scanned one row of LANES entries per cycle.
  localparam int PALETTE_ENTRIES_DEFAULT = 64;
  localparam int LANES                   = 4;
  localparam int LANE_W                  = $clog2(LANES);

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Run length at which a run is closed with the repeat byte.
  localparam logic [5:0] RUN_FULL    = 6'd63;
  localparam logic [7:0] BYTE_REPEAT = 8'hFF;
  localparam logic [1:0] TAG_RUN     = 2'b11;
  localparam logic [1:0] TAG_INDEX   = 2'b10;

  typedef struct packed {
    logic [14:0] pixel_color;
    logic        final_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       end_of_stream;
  } code_t;

  // One unit of work for the back: an optional leading byte, then an optional lookup.
  typedef struct packed {
    logic        pre_valid;
    logic [7:0]  pre_byte;
    logic        lookup;
    logic [14:0] color;
    logic        fin;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/lprpe_front.sv
// Front end: accepts pixels, tracks runs and turns byte-causing pixels into commands.
`default_nettype none

module lprpe_front
  import lprpe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pixel_valid,
  output logic        pixel_ready,
  input  wire pixel_t pixel,
  output logic        cmd_push,
  output cmd_t        cmd,
  input  wire logic   cmd_full
);

  logic        prev_valid, prev_valid_next;
  logic [14:0] prev_color, prev_color_next;
  logic        run_active, run_active_next;
  logic [5:0]  run_cnt, run_cnt_next;

  logic        accept;
  logic        same;
  logic        push;
  logic [5:0]  run_inc;

  assign pixel_ready = !cmd_full;
  assign accept      = pixel_valid && pixel_ready;
  assign same        = prev_valid && (pixel.pixel_color == prev_color);
  assign run_inc     = run_active ? run_cnt + 6'd1 : 6'd0;

  always_comb begin
    prev_valid_next = prev_valid;
    prev_color_next = prev_color;
    run_active_next = run_active;
    run_cnt_next    = run_cnt;
    push            = 1'b0;
    cmd.pre_valid   = 1'b0;
    cmd.pre_byte    = {TAG_RUN, run_cnt};
    cmd.lookup      = 1'b0;
    cmd.color       = pixel.pixel_color;
    cmd.fin         = pixel.final_pixel;
    if (same) begin
      if (run_inc == RUN_FULL) begin
        push            = 1'b1;
        cmd.pre_valid   = 1'b1;
        cmd.pre_byte    = BYTE_REPEAT;
        run_active_next = 1'b0;
      end else begin
        run_active_next = 1'b1;
        run_cnt_next    = run_inc;
        if (pixel.final_pixel) begin
          push          = 1'b1;
          cmd.pre_valid = 1'b1;
          cmd.pre_byte  = {TAG_RUN, run_inc};
        end
      end
    end else begin
      // A new color closes any open run and goes to the palette.
      push            = 1'b1;
      cmd.pre_valid   = run_active;
      cmd.lookup      = 1'b1;
      prev_valid_next = 1'b1;
      prev_color_next = pixel.pixel_color;
      run_active_next = 1'b0;
    end
    if (pixel.final_pixel) begin
      prev_valid_next = 1'b0;
      run_active_next = 1'b0;
    end
  end

  assign cmd_push = accept && push;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      run_active <= 1'b0;
    end else if (accept) begin
      prev_valid <= prev_valid_next;
      run_active <= run_active_next;
    end
    if (accept) begin
      prev_color <= prev_color_next;
      run_cnt    <= run_cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: design/lprpe_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module lprpe_queue
  import lprpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C = PW'(QUEUE_DEPTH - 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/lprpe_back.sv
// Back end: palette scan with least-recently-used replacement and byte emission.
`default_nettype none

module lprpe_back
  import lprpe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      code_valid,
  input  wire logic code_ready,
  output code_t     code
);

  localparam int ROWS_USED = (PALETTE_ENTRIES + LANES - 1) / LANES;
  localparam int RW        = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
  localparam int ROWS      = 2 ** RW;
  localparam int SW        = RW + LANE_W;
  localparam logic [RW-1:0] LAST_ROW = RW'((PALETTE_ENTRIES - 1) / LANES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EMIT1 = 3'd3;
  localparam logic [2:0] S_EMIT2 = 3'd4;

  typedef struct packed {
    logic              ok;
    logic [31:0]       st;
    logic [LANE_W-1:0] lane;
  } cand_t;

  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    if (!b.ok) begin
      r = a;
    end else if (!a.ok) begin
      r = b;
    end else begin
      r = (b.st < a.st) ? b : a;
    end
    return r;
  endfunction

  // Palette memories, one row of LANES entries per address.
  logic [LANES-1:0][14:0] pal_mem   [ROWS];
  logic [LANES-1:0][31:0] stamp_mem [ROWS];
  logic [LANES-1:0]       ev        [ROWS];

  logic [2:0]  state;
  cmd_t        cur;
  logic [31:0] stamp_counter;

  // Read stage.
  logic                   issue;
  logic [RW-1:0]          rd_row;
  logic                   issued_all;
  logic                   a_valid;
  logic [RW-1:0]          a_row;
  logic [LANES-1:0]       a_ev;
  logic [LANES-1:0][14:0] pal_rd;
  logic [LANES-1:0][31:0] stp_rd;

  // Row compare stage.
  logic              b_valid;
  logic [RW-1:0]     b_row;
  logic              b_hit;
  logic [LANE_W-1:0] b_hit_lane;
  logic [31:0]       b_min;
  logic [LANE_W-1:0] b_min_lane;

  logic              row_hit;
  logic [LANE_W-1:0] row_hit_lane;
  cand_t             lane_c [LANES];
  cand_t             pair0, pair1, row_min;

  // Merge stage.
  logic [31:0]   run_min;
  logic [SW-1:0] run_slot;
  logic          take_row;
  logic [31:0]   merged_min;
  logic [SW-1:0] merged_slot;
  logic          c_done;
  logic [SW-1:0] c_slot;

  logic          res_hit;
  logic [SW-1:0] res_slot;

  logic  out_free;
  logic  emit;
  code_t emit_code;
  logic  finish;
  logic  out_valid;
  code_t out_code;

  assign issue = (state == S_SCAN) && !issued_all;

  always_comb begin
    logic [14:0] val;
    logic [31:0] st;
    logic        in_range;
    row_hit      = 1'b0;
    row_hit_lane = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      in_range  = (int'(a_row) * LANES + j) < PALETTE_ENTRIES;
      val       = a_ev[j] ? pal_rd[j] : 15'd0;
      st        = a_ev[j] ? stp_rd[j] : 32'd0;
      lane_c[j] = '{ok: in_range, st: st, lane: LANE_W'(j)};
      if (in_range && (val == cur.color)) begin
        row_hit      = 1'b1;
        row_hit_lane = LANE_W'(j);
      end
    end
    pair0   = pick(lane_c[0], lane_c[1]);
    pair1   = pick(lane_c[2], lane_c[3]);
    row_min = pick(pair0, pair1);
  end

  always_comb begin
    take_row    = (b_row == '0) || (b_min < run_min);
    merged_min  = take_row ? b_min : run_min;
    merged_slot = take_row ? {b_row, b_min_lane} : run_slot;
    c_done      = b_valid && (b_hit || (b_row == LAST_ROW));
    c_slot      = b_hit ? {b_row, b_hit_lane} : merged_slot;
  end

  assign out_free = !out_valid || code_ready;

  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    finish    = 1'b0;
    emit_code = '{code_byte: cur.pre_byte, last_of_item: 1'b0, end_of_stream: 1'b0};
    case (state)
      S_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      S_PRE: begin
        emit      = out_free;
        emit_code = '{code_byte: cur.pre_byte, last_of_item: !cur.lookup,
                      end_of_stream: !cur.lookup && cur.fin};
        finish    = out_free && !cur.lookup;
      end
      S_EMIT1: begin
        emit = out_free;
        if (res_hit) begin
          emit_code = '{code_byte: {TAG_INDEX, 6'(res_slot)}, last_of_item: 1'b1,
                        end_of_stream: cur.fin};
          finish    = out_free;
        end else begin
          emit_code = '{code_byte: {1'b0, cur.color[14:8]}, last_of_item: 1'b0,
                        end_of_stream: 1'b0};
        end
      end
      S_EMIT2: begin
        emit      = out_free;
        emit_code = '{code_byte: cur.color[7:0], last_of_item: 1'b1,
                      end_of_stream: cur.fin};
        finish    = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stamp_counter <= '0;
      issued_all    <= 1'b0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      out_valid     <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        ev[r] <= '0;
      end
    end else begin
      a_valid <= issue && !c_done;
      b_valid <= a_valid && !c_done;
      if (state != S_SCAN) begin
        issued_all <= 1'b0;
      end else if (issue && (rd_row == LAST_ROW)) begin
        issued_all <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (code_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.lookup) begin
              stamp_counter <= stamp_counter + 32'd1;
            end
            state <= cmd.pre_valid ? S_PRE : S_SCAN;
          end
        end
        S_PRE: begin
          if (out_free) begin
            state <= cur.lookup ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          if (c_done) begin
            state <= S_EMIT1;
            ev[c_slot[SW-1:LANE_W]][c_slot[LANE_W-1:0]] <= 1'b1;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            state <= res_hit ? S_IDLE : S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // The end of an image returns the palette and the stamps to their reset values.
      if (finish && cur.fin) begin
        stamp_counter <= '0;
        for (int r = 0; r < ROWS; r++) begin
          ev[r] <= '0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state != S_SCAN) begin
      rd_row <= '0;
    end else if (issue) begin
      rd_row <= rd_row + 1'b1;
    end
    if (issue) begin
      pal_rd <= pal_mem[rd_row];
      stp_rd <= stamp_mem[rd_row];
      a_row  <= rd_row;
      a_ev   <= ev[rd_row];
    end
    if (a_valid) begin
      b_row      <= a_row;
      b_hit      <= row_hit;
      b_hit_lane <= row_hit_lane;
      b_min      <= row_min.st;
      b_min_lane <= row_min.lane;
    end
    if (b_valid) begin
      run_min  <= merged_min;
      run_slot <= merged_slot;
    end
    if (c_done) begin
      res_hit  <= b_hit;
      res_slot <= c_slot;
      pal_mem[c_slot[SW-1:LANE_W]][c_slot[LANE_W-1:0]]   <= cur.color;
      stamp_mem[c_slot[SW-1:LANE_W]][c_slot[LANE_W-1:0]] <= stamp_counter;
    end
    if (emit) begin
      out_code <= emit_code;
    end
  end

  assign code_valid = out_valid;
  assign code       = out_code;

endmodule

`default_nettype wire

// File: design/lru_palette_rle_pixel_encoder_unit.sv
// Top level of the palette and run-length pixel encoder.
//
// The pixel channel (pixel_valid, pixel_ready, pixel) takes one 15-bit color
// and a final-pixel flag per item. The code channel (code_valid, code_ready,
// code) delivers the compressed stream one byte per item, with last_of_item
// on the last byte a pixel causes and end_of_stream on the last byte of an
// image. A pixel that only extends a run causes no byte. Accepted pixels are
// classified by the front end, and those that cause bytes are queued as
// commands; the back end works on one command at a time. A new color is
// dequeued, emits any pending run byte, then scans the palette four entries
// per cycle through the read, row compare and merge stages, stopping early
// on a hit, then emits its bytes at one byte per cycle while the receiver
// accepts them. Each byte passes through the output register before it
// appears on code. Reset clears the run state, the queue, the output
// register and the palette valid bits, so the palette reads as all zero with
// zero stamps. When the receiver stalls, the output register holds its byte,
// the back end waits, and once the queue fills pixel_ready drops.
`default_nettype none

module lru_palette_rle_pixel_encoder_unit
  import lprpe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pixel_valid,
  output logic        pixel_ready,
  input  wire pixel_t pixel,
  output logic        code_valid,
  input  wire logic   code_ready,
  output code_t       code
);

  // Commands from the front end to the queue.
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;

  // Commands from the queue to the back end.
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;

  // The front end sees only whether the queue has room, so pixels keep
  // flowing while the back end scans the palette or waits on the receiver.
  lprpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  lprpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // The back end owns the palette, the use stamps and the output register.
  lprpe_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

endmodule

`default_nettype wire

// File: design/lprpe_checker.sv
// Port-level checks of the pixel encoder and the bind that attaches them.
`default_nettype none

module lprpe_checker
  import lprpe_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   pixel_valid,
  input wire logic   pixel_ready,
  input wire pixel_t pixel,
  input wire logic   code_valid,
  input wire logic   code_ready,
  input wire code_t  code
);

  // A waiting input item stays offered and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("waiting pixel item changed");

  // A stalled output item holds its value.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code))
    else $error("stalled code item changed");

  // Reset leaves no output item and a queue with room for a pixel.
  assert property (@(posedge clk) rst |=> !code_valid && pixel_ready)
    else $error("encoder not clear after reset");

  // The end of the stream is always the last byte of its pixel.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && code.end_of_stream |-> code.last_of_item)
    else $error("end of stream on a byte that is not last");

  // Palette index bytes always end their pixel's bytes.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && code.code_byte[7] && !code.code_byte[6] |-> code.last_of_item)
    else $error("index byte not marked last");

endmodule

bind lru_palette_rle_pixel_encoder_unit lprpe_checker u_lprpe_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .pixel       (pixel),
  .code_valid  (code_valid),
  .code_ready  (code_ready),
  .code        (code)
);

`default_nettype wire
